// ===== rtl/itp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_pkg
// Shared types, character codes and helper functions for the infix to
// postfix converter.
// ----------------------------------------------------------------------------
package itp_pkg;

   localparam int CHAR_W = 8;
   localparam int CODE_W = 3;

   localparam logic [CHAR_W-1:0] CH_LPAR = 8'h28;  // (
   localparam logic [CHAR_W-1:0] CH_RPAR = 8'h29;  // )
   localparam logic [CHAR_W-1:0] CH_EQ   = 8'h3D;  // =
   localparam logic [CHAR_W-1:0] CH_ADD  = 8'h2B;  // +
   localparam logic [CHAR_W-1:0] CH_SUB  = 8'h2D;  // -
   localparam logic [CHAR_W-1:0] CH_MUL  = 8'h2A;  // *
   localparam logic [CHAR_W-1:0] CH_DIV  = 8'h2F;  // /
   localparam logic [CHAR_W-1:0] CH_UA   = 8'h41;  // A
   localparam logic [CHAR_W-1:0] CH_UZ   = 8'h5A;  // Z
   localparam logic [CHAR_W-1:0] CH_LA   = 8'h61;  // a
   localparam logic [CHAR_W-1:0] CH_LZ   = 8'h7A;  // z
   localparam logic [CHAR_W-1:0] CH_D0   = 8'h30;  // 0
   localparam logic [CHAR_W-1:0] CH_D9   = 8'h39;  // 9

   localparam logic [CODE_W-1:0] CODE_NONE = 3'd0;
   localparam logic [CODE_W-1:0] CODE_LPAR = 3'd1;
   localparam logic [CODE_W-1:0] CODE_ADD  = 3'd2;
   localparam logic [CODE_W-1:0] CODE_SUB  = 3'd3;
   localparam logic [CODE_W-1:0] CODE_MUL  = 3'd4;
   localparam logic [CODE_W-1:0] CODE_DIV  = 3'd5;

   typedef enum logic [2:0] {
      KIND_OTHER,
      KIND_OPERAND,
      KIND_LPAR,
      KIND_RPAR,
      KIND_EQ,
      KIND_OP
   } kind_type;

   typedef enum logic [1:0] {
      SEL_IN,
      SEL_TOP,
      SEL_EQ
   } emit_sel_type;

   typedef struct packed {
      logic         latch;
      logic         push_in;
      logic         push_cur;
      logic         read;
      logic         pop;
      logic         emit;
      emit_sel_type emit_sel;
      logic         emit_last;
   } cmd_type;

   typedef struct packed {
      kind_type in_kind;
      kind_type cur_kind;
      logic     count_zero;
      logic     count_one;
      logic     top_lpar;
      logic     top_rank_lt;
      logic     below_lpar;
      logic     below_rank_lt;
      logic     out_free;
   } status_type;

   function automatic kind_type classify(input logic [CHAR_W-1:0] ch);
      kind_type k;
      k = KIND_OTHER;
      if ((ch >= CH_UA && ch <= CH_UZ) || (ch >= CH_LA && ch <= CH_LZ) ||
          (ch >= CH_D0 && ch <= CH_D9))
         k = KIND_OPERAND;
      else if (ch == CH_LPAR)
         k = KIND_LPAR;
      else if (ch == CH_RPAR)
         k = KIND_RPAR;
      else if (ch == CH_EQ)
         k = KIND_EQ;
      else if (ch == CH_ADD || ch == CH_SUB || ch == CH_MUL || ch == CH_DIV)
         k = KIND_OP;
      return k;
   endfunction

   function automatic logic [CODE_W-1:0] code_of(input logic [CHAR_W-1:0] ch);
      logic [CODE_W-1:0] c;
      case (ch)
         CH_LPAR: c = CODE_LPAR;
         CH_ADD:  c = CODE_ADD;
         CH_SUB:  c = CODE_SUB;
         CH_MUL:  c = CODE_MUL;
         CH_DIV:  c = CODE_DIV;
         default: c = CODE_NONE;
      endcase
      return c;
   endfunction

   function automatic logic [CHAR_W-1:0] char_of(input logic [CODE_W-1:0] c);
      logic [CHAR_W-1:0] ch;
      case (c)
         CODE_LPAR: ch = CH_LPAR;
         CODE_ADD:  ch = CH_ADD;
         CODE_SUB:  ch = CH_SUB;
         CODE_MUL:  ch = CH_MUL;
         CODE_DIV:  ch = CH_DIV;
         default:   ch = '0;
      endcase
      return ch;
   endfunction

   function automatic logic [1:0] rank_of(input logic [CODE_W-1:0] c);
      logic [1:0] r;
      case (c)
         CODE_MUL, CODE_DIV: r = 2'd2;
         CODE_ADD, CODE_SUB: r = 2'd1;
         default:            r = 2'd0;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/infix_to_postfix_converter.sv =====
`timescale 1ns / 1ps
// An operand word shows on rsp in the cycle after it is taken; '(' and
// ignored characters are handled without leaving the idle state. ')', '='
// and operators pass the check state (one memory read) and the pop state for
// each stack entry popped; a new character is taken only in the idle state.
// Reset clears the stack count, overflow flag, output valid and the sequencer.
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard converter: one infix character in, postfix words out.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter #(
   parameter int STACK_DEPTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [itp_pkg::CHAR_W-1:0] req_in_char,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [itp_pkg::CHAR_W-1:0] rsp_out_char,
   output logic                       rsp_last,
   output logic                       rsp_overflow_seen
);
   import itp_pkg::*;

   cmd_type    cmd;
   status_type sts;

   itp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   itp_dpath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_in_char       (req_in_char),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_out_char      (rsp_out_char),
      .rsp_last          (rsp_last),
      .rsp_overflow_seen (rsp_overflow_seen),
      .cmd               (cmd),
      .sts               (sts)
   );

endmodule

// ===== rtl/itp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_ctrl
// Sequencer: accepts characters and steps the operator stack through its
// check, pop and emit phases.
// ----------------------------------------------------------------------------
module itp_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  itp_pkg::status_type sts,
   output itp_pkg::cmd_type    cmd
);
   import itp_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CHECK,
      S_POP,
      S_EQ
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.emit_sel  = SEL_IN;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = sts.out_free;
            if (req_valid && sts.out_free) begin
               cmd.latch = 1'b1;
               case (sts.in_kind)
                  KIND_OPERAND: begin
                     cmd.emit      = 1'b1;
                     cmd.emit_sel  = SEL_IN;
                     cmd.emit_last = 1'b1;
                  end
                  KIND_LPAR: cmd.push_in = 1'b1;
                  KIND_RPAR, KIND_EQ, KIND_OP: state_in = S_CHECK;
                  default: ;
               endcase
            end
         end
         S_CHECK: begin
            // fetch the entry below the top for the next pop
            cmd.read = 1'b1;
            if (sts.count_zero) begin
               case (sts.cur_kind)
                  KIND_EQ: state_in = S_EQ;
                  KIND_OP: begin
                     cmd.push_cur = 1'b1;
                     state_in     = S_IDLE;
                  end
                  default: state_in = S_IDLE;
               endcase
            end else if (sts.cur_kind == KIND_OP &&
                         (sts.top_lpar || sts.top_rank_lt)) begin
               cmd.push_cur = 1'b1;
               state_in     = S_IDLE;
            end else begin
               state_in = S_POP;
            end
         end
         S_POP: begin
            if (sts.top_lpar) begin
               // drop the paren without a word
               cmd.pop = 1'b1;
               if (sts.cur_kind == KIND_EQ)
                  state_in = sts.count_one ? S_EQ : S_CHECK;
               else
                  state_in = S_IDLE;
            end else if (sts.out_free) begin
               cmd.pop      = 1'b1;
               cmd.emit     = 1'b1;
               cmd.emit_sel = SEL_TOP;
               case (sts.cur_kind)
                  KIND_RPAR: begin
                     cmd.emit_last = sts.count_one || sts.below_lpar;
                     state_in      = sts.count_one ? S_IDLE : S_CHECK;
                  end
                  KIND_EQ: begin
                     cmd.emit_last = 1'b0;
                     state_in      = sts.count_one ? S_EQ : S_CHECK;
                  end
                  default: begin
                     cmd.emit_last = sts.count_one || sts.below_lpar ||
                                     sts.below_rank_lt;
                     state_in      = S_CHECK;
                  end
               endcase
            end
         end
         S_EQ: begin
            if (sts.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_sel  = SEL_EQ;
               cmd.emit_last = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

// ===== rtl/itp_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_dpath
// Operator stack memory with a cached top entry, stack count, sticky
// overflow flag and the result output register.
// ----------------------------------------------------------------------------
module itp_dpath #(
   parameter int STACK_DEPTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [itp_pkg::CHAR_W-1:0]  req_in_char,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output logic [itp_pkg::CHAR_W-1:0]  rsp_out_char,
   output logic                        rsp_last,
   output logic                        rsp_overflow_seen,
   input  itp_pkg::cmd_type            cmd,
   output itp_pkg::status_type         sts
);
   import itp_pkg::*;

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);

   logic [CODE_W-1:0] mem [STACK_DEPTH];

   logic [CW-1:0]     count_ff;
   logic              overflow_ff;
   logic [CODE_W-1:0] top_ff;
   logic [CODE_W-1:0] below_ff;
   logic [CODE_W-1:0] cur_code_ff;
   kind_type          cur_kind_ff;
   logic              rsp_valid_ff;
   logic [CHAR_W-1:0] rsp_char_ff;
   logic              rsp_last_ff;
   logic              rsp_ovf_ff;

   logic              full;
   logic              push;
   logic [CODE_W-1:0] push_code;
   logic [CHAR_W-1:0] emit_char;
   logic [AW-1:0]     rd_idx;
   logic [AW-1:0]     wr_idx;

   assign full      = (count_ff == CW'(STACK_DEPTH));
   assign push      = cmd.push_in || cmd.push_cur;
   assign push_code = cmd.push_in ? CODE_LPAR : cur_code_ff;
   assign rd_idx    = AW'(count_ff - CW'(2));
   assign wr_idx    = AW'(count_ff);

   always_comb begin
      case (cmd.emit_sel)
         SEL_TOP: emit_char = char_of(top_ff);
         SEL_EQ:  emit_char = CH_EQ;
         default: emit_char = req_in_char;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push && !full)
         mem[wr_idx] <= push_code;
      if (cmd.read)
         below_ff <= mem[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (push) begin
            if (full)
               overflow_ff <= 1'b1;
            else
               count_ff <= count_ff + CW'(1);
         end else if (cmd.pop) begin
            count_ff <= count_ff - CW'(1);
         end
         if (cmd.emit)
            rsp_valid_ff <= 1'b1;
         else if (rsp_ready)
            rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full)
         top_ff <= push_code;
      else if (cmd.pop)
         top_ff <= below_ff;
      if (cmd.latch) begin
         cur_code_ff <= code_of(req_in_char);
         cur_kind_ff <= classify(req_in_char);
      end
      if (cmd.emit) begin
         rsp_char_ff <= emit_char;
         rsp_last_ff <= cmd.emit_last;
         rsp_ovf_ff  <= overflow_ff;
      end
   end

   always_comb begin
      sts.in_kind       = classify(req_in_char);
      sts.cur_kind      = cur_kind_ff;
      sts.count_zero    = (count_ff == '0);
      sts.count_one     = (count_ff == CW'(1));
      sts.top_lpar      = (top_ff == CODE_LPAR);
      sts.top_rank_lt   = (rank_of(top_ff) < rank_of(cur_code_ff));
      sts.below_lpar    = (below_ff == CODE_LPAR);
      sts.below_rank_lt = (rank_of(below_ff) < rank_of(cur_code_ff));
      sts.out_free      = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_char      = rsp_char_ff;
   assign rsp_last          = rsp_last_ff;
   assign rsp_overflow_seen = rsp_ovf_ff;

endmodule
